>>> src/alr_pkg.sv
// Shared types and constants of the anti-aliased line rasterizer.
package alr_pkg;

   localparam int COORD_W = 6;
   localparam int COLOR_W = 8;
   localparam int SIDE_W  = 8;
   localparam int ERR_W   = 7;
   localparam int PROD_W  = 15;

   localparam logic MODE_MOVE = 1'b0;
   localparam logic MODE_LINE = 1'b1;

   // One classified line, handed from the front to the back.
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] major_len;
      logic [COORD_W-1:0] minor_len;
      logic               steep;
      logic               down;
      logic               vertical;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } cmd_type;

   // One pixel step as it leaves the block.
   typedef struct packed {
      logic [COORD_W-1:0]       main_x;
      logic [COORD_W-1:0]       main_y;
      logic [COLOR_W-1:0]       main_red;
      logic [COLOR_W-1:0]       main_green;
      logic [COLOR_W-1:0]       main_blue;
      logic signed [SIDE_W-1:0] side_x;
      logic signed [SIDE_W-1:0] side_y;
      logic [COLOR_W-1:0]       side_level;
      logic                     side_valid;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_LOAD,
      BACK_DIVIDE,
      BACK_EMIT
   } back_state_type;

endpackage

>>> src/alr_fifo.sv
// Small register-based queue used between the stages and at the result port.
module alr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/alr_front.sv
// Front stage: takes commands, tracks the pen, and classifies each line.
module alr_front #(
   parameter int MAX_COORD = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                mode,
   input  logic [5:0]          target_x,
   input  logic [5:0]          target_y,
   input  logic [7:0]          pen_red,
   input  logic [7:0]          pen_green,
   input  logic [7:0]          pen_blue,
   input  logic                queue_full,
   output logic                cmd_push,
   output alr_pkg::cmd_type    cmd_data
);
   import alr_pkg::*;

   localparam logic [COORD_W-1:0] MaxCoordC = COORD_W'(MAX_COORD);

   logic [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic [COLOR_W-1:0] cur_red_ff, cur_green_ff, cur_blue_ff;
   logic [COORD_W-1:0] tx, ty;
   logic [COORD_W-1:0] x0, y0, x1, y1, dx, ady, v_lo, v_len;
   logic               accept, vertical, above, swap, down, steep;

   assign full   = queue_full;
   assign accept = push && !queue_full;

   assign tx = (target_x > MaxCoordC) ? MaxCoordC : target_x;
   assign ty = (target_y > MaxCoordC) ? MaxCoordC : target_y;

   always_comb begin
      vertical = (cur_x_ff == tx);
      above    = (cur_y_ff > ty);
      v_lo     = above ? ty : cur_y_ff;
      v_len    = above ? (cur_y_ff - ty) : (ty - cur_y_ff);

      // Sloped lines are always walked from the left end.
      swap  = (cur_x_ff > tx);
      x0    = swap ? tx : cur_x_ff;
      y0    = swap ? ty : cur_y_ff;
      x1    = swap ? cur_x_ff : tx;
      y1    = swap ? cur_y_ff : ty;
      dx    = x1 - x0;
      down  = (y1 < y0);
      ady   = down ? (y0 - y1) : (y1 - y0);
      steep = (ady > dx);

      if (vertical) begin
         cmd_data.start_x   = cur_x_ff;
         cmd_data.start_y   = v_lo;
         cmd_data.major_len = v_len;
         cmd_data.minor_len = '0;
         cmd_data.steep     = 1'b0;
         cmd_data.down      = 1'b0;
         cmd_data.vertical  = 1'b1;
         // The column takes the color of its lower end.
         cmd_data.red       = above ? pen_red   : cur_red_ff;
         cmd_data.green     = above ? pen_green : cur_green_ff;
         cmd_data.blue      = above ? pen_blue  : cur_blue_ff;
      end else begin
         cmd_data.start_x   = x0;
         cmd_data.start_y   = y0;
         cmd_data.major_len = steep ? ady : dx;
         cmd_data.minor_len = steep ? dx : ady;
         cmd_data.steep     = steep;
         cmd_data.down      = down;
         cmd_data.vertical  = 1'b0;
         cmd_data.red       = pen_red;
         cmd_data.green     = pen_green;
         cmd_data.blue      = pen_blue;
      end

      cmd_push = accept && (mode == MODE_LINE) && (cmd_data.major_len != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_red_ff   <= '0;
         cur_green_ff <= '0;
         cur_blue_ff  <= '0;
      end else if (accept) begin
         cur_x_ff     <= tx;
         cur_y_ff     <= ty;
         cur_red_ff   <= pen_red;
         cur_green_ff <= pen_green;
         cur_blue_ff  <= pen_blue;
      end
   end

endmodule

>>> src/alr_back.sv
// Back stage: walks each line and computes gray levels with a serial divider.
module alr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  alr_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output alr_pkg::rsp_type rsp_data
);
   import alr_pkg::*;

   back_state_type     state_ff, state_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0] major_ff, major_in, minor_ff, minor_in;
   logic [COORD_W-1:0] count_ff, count_in;
   logic               steep_ff, steep_in, down_ff, down_in, vert_ff, vert_in;
   logic [COLOR_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COLOR_W-1:0] quo_ff, quo_in;
   logic [2:0]         bit_ff, bit_in;
   logic [PROD_W-1:0]  product;
   logic [COORD_W:0]   trial;
   logic               trial_ge;
   logic [ERR_W-1:0]   err_sum;
   logic               wrap;
   logic [COORD_W-1:0] y_step;
   logic [SIDE_W-1:0]  wide_x, wide_y;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      count_in = count_ff;
      steep_in = steep_ff;
      down_in  = down_ff;
      vert_in  = vert_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      err_in   = err_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;

      // 255 * err, and one restoring divide step by the major length.
      product  = {err_ff, 8'b0} - {8'b0, err_ff};
      trial    = {rem_ff, quo_ff[COLOR_W-1]};
      trial_ge = (trial >= {1'b0, major_ff});

      // Error update for the next step of a sloped line.
      err_sum = err_ff + {1'b0, minor_ff};
      wrap    = (err_sum >= {1'b0, major_ff});
      y_step  = (steep_ff || wrap) ? COORD_W'(1) : '0;

      unique case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               x_in     = cmd_data.start_x;
               y_in     = cmd_data.start_y;
               major_in = cmd_data.major_len;
               minor_in = cmd_data.minor_len;
               count_in = cmd_data.major_len;
               steep_in = cmd_data.steep;
               down_in  = cmd_data.down;
               vert_in  = cmd_data.vertical;
               red_in   = cmd_data.red;
               green_in = cmd_data.green;
               blue_in  = cmd_data.blue;
               err_in   = {1'b0, cmd_data.minor_len};
               state_in = cmd_data.vertical ? BACK_EMIT : BACK_LOAD;
            end
         end
         BACK_LOAD: begin
            // The quotient never exceeds 255, so the top bits are already a remainder.
            rem_in   = product[13:8];
            quo_in   = product[7:0];
            bit_in   = '0;
            state_in = BACK_DIVIDE;
         end
         BACK_DIVIDE: begin
            rem_in = trial_ge ? COORD_W'(trial - {1'b0, major_ff}) : trial[COORD_W-1:0];
            quo_in = {quo_ff[COLOR_W-2:0], trial_ge};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 3'd7) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               count_in = count_ff - 1'b1;
               if (vert_ff) begin
                  y_in = y_ff + 1'b1;
               end else begin
                  err_in = wrap ? (err_sum - {1'b0, major_ff}) : err_sum;
                  x_in   = x_ff + ((steep_ff && !wrap) ? '0 : COORD_W'(1));
                  y_in   = down_ff ? (y_ff - y_step) : (y_ff + y_step);
               end
               if (count_ff == COORD_W'(1)) begin
                  state_in = BACK_IDLE;
               end else if (!vert_ff) begin
                  state_in = BACK_LOAD;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      wide_x = {2'b00, x_ff};
      wide_y = {2'b00, y_ff};
      rsp_data.main_x = x_ff;
      rsp_data.main_y = y_ff;
      rsp_data.last   = (count_ff == COORD_W'(1));
      if (vert_ff) begin
         rsp_data.main_red   = red_ff;
         rsp_data.main_green = green_ff;
         rsp_data.main_blue  = blue_ff;
         rsp_data.side_x     = '0;
         rsp_data.side_y     = '0;
         rsp_data.side_level = '0;
         rsp_data.side_valid = 1'b0;
      end else begin
         rsp_data.main_red   = quo_ff;
         rsp_data.main_green = quo_ff;
         rsp_data.main_blue  = quo_ff;
         rsp_data.side_x     = steep_ff ? $signed(wide_x + 8'd1) : $signed(wide_x);
         if (steep_ff) begin
            rsp_data.side_y = $signed(wide_y);
         end else if (down_ff) begin
            rsp_data.side_y = $signed(wide_y - 8'd1);
         end else begin
            rsp_data.side_y = $signed(wide_y + 8'd1);
         end
         rsp_data.side_level = ~quo_ff;
         rsp_data.side_valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         count_ff <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      steep_ff <= steep_in;
      down_ff  <= down_in;
      vert_ff  <= vert_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      err_ff   <= err_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

endmodule

>>> src/antialiased_line_rasterizer.sv
// Top level of the anti-aliased line rasterizer for a 64x64 tile.
//
// The block draws lines pen-style: a move beat sets the current point and color, a line
// beat draws from the current point to the target and then makes the target current.
// Vertical lines produce one pen-colored pixel per row, from the lower end up to but
// excluding the upper end. Every other line produces one result beat per step along its
// major axis, each carrying a main pixel with gray level floor(255*e) and a neighbor
// with 255 minus that level, where e is an exact rational error term. Moves and
// zero-length lines produce no result beat. Target coordinates above MAX_COORD are
// clamped to MAX_COORD. Command beats enter through a front stage that tracks the pen and
// classifies the line, then wait in a small command queue; a back stage walks the line
// and writes result beats into a small result queue. Every step of a sloped line runs an
// operand setup, the shared restoring divider that forms the gray level, and a write of
// the result beat. A vertical line produces one pixel per cycle while the result queue
// is not full. The front accepts new command beats while the back is busy until the
// command queue holds CMD_DEPTH lines, and results wait in the result queue for pop.
module antialiased_line_rasterizer #(
   parameter int MAX_COORD = 63,
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_mode,
   input  logic [5:0]        req_target_x,
   input  logic [5:0]        req_target_y,
   input  logic [7:0]        req_pen_red,
   input  logic [7:0]        req_pen_green,
   input  logic [7:0]        req_pen_blue,
   output logic              empty,
   input  logic              pop,
   output logic [5:0]        rsp_main_x,
   output logic [5:0]        rsp_main_y,
   output logic [7:0]        rsp_main_red,
   output logic [7:0]        rsp_main_green,
   output logic [7:0]        rsp_main_blue,
   output logic signed [7:0] rsp_side_x,
   output logic signed [7:0] rsp_side_y,
   output logic [7:0]        rsp_side_level,
   output logic              rsp_side_valid,
   output logic              rsp_last
);
   import alr_pkg::*;

   cmd_type front_cmd, back_cmd;
   rsp_type back_rsp, out_rsp;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic    rsp_push, rsp_full;

   // Front: pen tracking and line classification.
   alr_front #(
      .MAX_COORD(MAX_COORD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .mode       (req_mode),
      .target_x   (req_target_x),
      .target_y   (req_target_y),
      .pen_red    (req_pen_red),
      .pen_green  (req_pen_green),
      .pen_blue   (req_pen_blue),
      .queue_full (cmd_full),
      .cmd_push   (cmd_push),
      .cmd_data   (front_cmd)
   );

   // Classified lines wait here so the front and back stall independently.
   alr_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (back_cmd),
      .empty   (cmd_empty)
   );

   // Back: line walker with the serial gray-level divider.
   alr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp)
   );

   // Result queue: the oldest pixel step is presented while empty is low.
   alr_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (out_rsp),
      .empty   (empty)
   );

   assign rsp_main_x     = out_rsp.main_x;
   assign rsp_main_y     = out_rsp.main_y;
   assign rsp_main_red   = out_rsp.main_red;
   assign rsp_main_green = out_rsp.main_green;
   assign rsp_main_blue  = out_rsp.main_blue;
   assign rsp_side_x     = out_rsp.side_x;
   assign rsp_side_y     = out_rsp.side_y;
   assign rsp_side_level = out_rsp.side_level;
   assign rsp_side_valid = out_rsp.side_valid;
   assign rsp_last       = out_rsp.last;

endmodule

>>> src/alr_checker.sv
// Port-level assertions for the rasterizer, bound to its top level.
module alr_port_assertions (
   input logic              clock,
   input logic              reset,
   input logic              empty,
   input logic              pop,
   input logic [5:0]        rsp_main_x,
   input logic [5:0]        rsp_main_y,
   input logic [7:0]        rsp_main_red,
   input logic [7:0]        rsp_main_green,
   input logic [7:0]        rsp_main_blue,
   input logic signed [7:0] rsp_side_x,
   input logic signed [7:0] rsp_side_y,
   input logic [7:0]        rsp_side_level,
   input logic              rsp_side_valid,
   input logic              rsp_last
);

   // Reset drains the result queue.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   // A waiting result beat holds until it is popped.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_main_x) && $stable(rsp_main_y)
         && $stable(rsp_main_red) && $stable(rsp_side_level) && $stable(rsp_last)))
      else $error("result beat changed while stalled");

   // Sloped pixels are gray and the pair levels add to full scale.
   a_grey_pair: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_side_valid) |-> (rsp_side_level == ~rsp_main_red
         && rsp_main_red == rsp_main_green && rsp_main_green == rsp_main_blue))
      else $error("sloped pixel pair levels inconsistent");

   // Vertical lines carry no neighbor.
   a_no_side: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_side_valid) |-> (rsp_side_x == 8'sd0 && rsp_side_y == 8'sd0
         && rsp_side_level == 8'd0))
      else $error("vertical pixel carries neighbor data");

   // The neighbor sits one column right or one row above or below the main pixel.
   a_side_adjacent: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_side_valid) |->
         (($unsigned(rsp_side_x) == {2'b00, rsp_main_x} + 8'd1
            && $unsigned(rsp_side_y) == {2'b00, rsp_main_y})
         || ($unsigned(rsp_side_x) == {2'b00, rsp_main_x}
            && ($unsigned(rsp_side_y) == {2'b00, rsp_main_y} + 8'd1
               || $unsigned(rsp_side_y) == {2'b00, rsp_main_y} - 8'd1))))
      else $error("neighbor pixel not adjacent to main pixel");

endmodule

bind antialiased_line_rasterizer alr_port_assertions u_checker (.*);
